>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk with the active-low
// synchronous reset rst_n. Defining NO_ASSERTIONS removes them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked outside reset only.
`define EFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define EFG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define EFG_ASSERT(lbl, prop, msg)
`define EFG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/core/efg_pkg.sv
// ----------------------------------------------------------------------------
// Event flag group package
// Shared widths, defaults, operation codes, sequencer states and the control
// bundle handed to the wait-entry match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package efg_pkg;

  // Default sizes of the block.
  localparam int DEF_NUM_TASKS  = 16;
  localparam int DEF_NUM_GROUPS = 8;
  localparam int DEF_FLAG_WIDTH = 32;

  // Fixed port widths.
  localparam int GROUP_ID_W = 3;
  localparam int BITS_W     = 32;
  localparam int TASK_ID_W  = 4;
  localparam int WOKEN_W    = 16;
  localparam int FLAGS_W    = 32;

  // Operation codes.
  localparam logic OP_POST = 1'b0;
  localparam logic OP_PEND = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } efg_state_t;

  // Controls for one wait-entry comparison.
  typedef struct packed {
    logic entry_valid;
    logic group_hit;
    logic all_mode;
  } efg_scan_t;

endpackage

`default_nettype wire

>>> rtl/core/efg_match.sv
// ----------------------------------------------------------------------------
// Wait-entry match unit
// Decides whether one waiting task is released by the posted flags, in either
// all-bits or any-bit mode. Shared by every step of the post scan.
// ----------------------------------------------------------------------------
`default_nettype none

module efg_match
  import efg_pkg::*;
#(
  parameter int FW = DEF_FLAG_WIDTH
) (
  input  efg_scan_t         ctl,
  input  logic [FW-1:0]     flags,
  input  logic [FW-1:0]     mask,
  output logic              hit
);

  logic [FW-1:0] common;
  logic          cond;

  // All-mode needs every awaited bit; any-mode needs at least one.
  always_comb begin
    common = flags & mask;
    cond   = ctl.all_mode ? (common == mask) : (|common);
    hit    = ctl.entry_valid && ctl.group_hit && cond;
  end

endmodule

`default_nettype wire

>>> rtl/core/event_flag_group_unit.sv
// ----------------------------------------------------------------------------
// Event flag group unit
// Event-flag groups with post and pend requests. A post ORs flags into a group
// and then scans the task wait entries one per cycle to wake matching tasks.
// ----------------------------------------------------------------------------
// A pend gives its result in the cycle after acceptance.
// A post scans one wait entry per cycle through the shared match unit,
// holding the last entry for a free result; input is not taken during the scan.
// A new request is taken once the result register is free or being drained.
// Synchronous active-low reset clears all group flags and wait entries and
// marks every task ready; there is no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module event_flag_group_unit
  import efg_pkg::*;
#(
  parameter int NUM_TASKS  = DEF_NUM_TASKS,
  parameter int NUM_GROUPS = DEF_NUM_GROUPS,
  parameter int FLAG_WIDTH = DEF_FLAG_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [GROUP_ID_W-1:0] in_group_id,
  input  logic [BITS_W-1:0]     in_bits,
  input  logic                  in_mode,
  input  logic [TASK_ID_W-1:0]  in_task_id,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_satisfied,
  output logic                  out_blocked,
  output logic                  out_reschedule,
  output logic [WOKEN_W-1:0]    out_woken_tasks,
  output logic [FLAGS_W-1:0]    out_group_flags
);

  // Reachable sizes: ids and flags wider than the ports can never be used.
  localparam int NT = (NUM_TASKS < (1 << TASK_ID_W)) ? NUM_TASKS : (1 << TASK_ID_W);
  localparam int NG = (NUM_GROUPS < (1 << GROUP_ID_W)) ? NUM_GROUPS : (1 << GROUP_ID_W);
  localparam int FW = (FLAG_WIDTH < BITS_W) ? FLAG_WIDTH : BITS_W;
  localparam int IW = $clog2(NT);
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  // Storage.
  logic [FW-1:0] flag_store_r [NG];
  logic [NT-1:0] wait_valid_r;
  logic [GW-1:0] wait_group_r [NT];
  logic [FW-1:0] wait_mask_r  [NT];
  logic [NT-1:0] ready_map_r;

  // Sequencer and scan context.
  efg_state_t    state_r, state_nxt;
  logic [IW-1:0] idx_r;
  logic [GW-1:0] grp_r;
  logic          all_mode_r;
  logic [FW-1:0] flags_r;
  logic [NT-1:0] woken_r;

  // Result register.
  logic               out_valid_r;
  logic               out_sat_r;
  logic               out_blk_r;
  logic [WOKEN_W-1:0] out_woken_r;
  logic [FLAGS_W-1:0] out_flags_r;

  // Request decode.
  logic          accept;
  logic          out_free;
  logic          grp_ok;
  logic          task_ok;
  logic [GW-1:0] gidx;
  logic [IW-1:0] tidx;
  logic [FW-1:0] req;
  logic [FW-1:0] cur_flags;
  logic [FW-1:0] post_flags;
  logic          pend_sat;
  logic [FW-1:0] pend_flags;
  logic          start_scan;
  logic          load_imm;
  logic          load_scan;
  logic          scan_last;

  // Scan step.
  efg_scan_t     scan_ctl;
  logic          scan_hit;
  logic [NT-1:0] woken_cur;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign grp_ok   = ({1'b0, in_group_id} < (GROUP_ID_W + 1)'(NG));
  assign task_ok  = ({1'b0, in_task_id} < (TASK_ID_W + 1)'(NT));
  assign gidx     = in_group_id[GW-1:0];
  assign tidx     = in_task_id[IW-1:0];
  assign req      = in_bits[FW-1:0];

  // Flag arithmetic for the addressed group.
  always_comb begin
    cur_flags  = flag_store_r[gidx];
    post_flags = cur_flags | req;
    pend_sat   = ((cur_flags & req) == req);
    pend_flags = (pend_sat && in_mode) ? (cur_flags & ~req) : cur_flags;
  end

  // Shared comparison of the current wait entry against the posted flags.
  always_comb begin
    scan_ctl.entry_valid = wait_valid_r[idx_r];
    scan_ctl.group_hit   = (wait_group_r[idx_r] == grp_r);
    scan_ctl.all_mode    = all_mode_r;
  end

  efg_match #(
    .FW (FW)
  ) u_match (
    .ctl   (scan_ctl),
    .flags (flags_r),
    .mask  (wait_mask_r[idx_r]),
    .hit   (scan_hit)
  );

  always_comb begin
    woken_cur        = woken_r;
    woken_cur[idx_r] = woken_r[idx_r] | scan_hit;
  end

  assign scan_last = (idx_r == IW'(NT - 1));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_POST) && grp_ok) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    start_scan = 1'b0;
    load_imm   = 1'b0;
    load_scan  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = out_free;
        start_scan = accept && (in_op == OP_POST) && grp_ok;
        load_imm   = accept && !((in_op == OP_POST) && grp_ok);
      end
      ST_SCAN: begin
        load_scan = scan_last && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers and stored state with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      wait_valid_r <= '0;
      ready_map_r  <= '1;
      for (int g = 0; g < NG; g++) begin
        flag_store_r[g] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Result register handshake.
      if (load_imm || load_scan) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Post: merge flags, then walk the wait entries.
      if (start_scan) begin
        flag_store_r[gidx] <= post_flags;
        idx_r              <= '0;
      end else if (state_r == ST_SCAN) begin
        if (scan_hit) begin
          ready_map_r[idx_r] <= 1'b1;
        end
        if (!scan_last) begin
          idx_r <= idx_r + 1'b1;
        end else if (out_free) begin
          idx_r <= '0;
        end
      end

      // Pend: record the wait entry, then consume or block.
      if (accept && (in_op == OP_PEND) && grp_ok && task_ok) begin
        wait_valid_r[tidx] <= 1'b1;
        flag_store_r[gidx] <= pend_flags;
        if (!pend_sat) begin
          ready_map_r[tidx] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_PEND) && grp_ok && task_ok) begin
      wait_group_r[tidx] <= gidx;
      wait_mask_r[tidx]  <= req;
    end

    if (start_scan) begin
      grp_r      <= gidx;
      all_mode_r <= in_mode;
      flags_r    <= post_flags;
      woken_r    <= '0;
    end else if (state_r == ST_SCAN) begin
      woken_r <= woken_cur;
    end

    if (load_imm) begin
      out_woken_r <= '0;
      if (!grp_ok) begin
        out_sat_r   <= 1'b0;
        out_blk_r   <= 1'b0;
        out_flags_r <= '0;
      end else if (task_ok) begin
        out_sat_r   <= pend_sat;
        out_blk_r   <= !pend_sat;
        out_flags_r <= FLAGS_W'(pend_flags);
      end else begin
        out_sat_r   <= 1'b0;
        out_blk_r   <= 1'b0;
        out_flags_r <= FLAGS_W'(cur_flags);
      end
    end else if (load_scan) begin
      out_sat_r   <= 1'b0;
      out_blk_r   <= 1'b0;
      out_woken_r <= WOKEN_W'(woken_cur);
      out_flags_r <= FLAGS_W'(flags_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_satisfied   = out_sat_r;
  assign out_blocked     = out_blk_r;
  assign out_reschedule  = out_blk_r;
  assign out_woken_tasks = out_woken_r;
  assign out_group_flags = out_flags_r;

  // Assertions.
  `EFG_ASSERT(a_pend_result_next, (accept && (in_op == OP_PEND)) |=> out_valid, "pend result missing")
  `EFG_ASSERT(a_sat_blk_excl, out_valid |-> !(out_satisfied && out_blocked), "satisfied and blocked")
  `EFG_ASSERT(a_woken_only_post, (out_valid && (out_woken_tasks != '0)) |-> !(out_satisfied || out_blocked), "woken on pend")
  `EFG_ASSERT(a_no_accept_scan, (state_r == ST_SCAN) |-> !in_ready, "request taken during scan")
  `EFG_ASSERT(a_reset_idle, !$past(rst_n) |-> (state_r == ST_IDLE && !out_valid_r), "not idle after reset")

endmodule

`default_nettype wire
